@@ src/slefd_pkg.sv @@
// ----------------------------------------------------------------------------
// slefd_pkg: shared types and constants of the start/length/end deframer
// Request and result layouts, request codes, register indexes, back-end states.
// ----------------------------------------------------------------------------
package slefd_pkg;

    // frame layout
    localparam int HDR_MIN    = 4;
    localparam int LEN_OFFSET = 2;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // stream widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int TUSER_W     = 2;

    // request codes on the input tuser
    localparam logic [TUSER_W-1:0] REQ_CODE_PUSH    = 2'd0;
    localparam logic [TUSER_W-1:0] REQ_CODE_READ    = 2'd1;
    localparam logic [TUSER_W-1:0] REQ_CODE_RELEASE = 2'd2;

    // configuration register indexes
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_MARKER = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_END_MARKER   = 1'b1;

    typedef enum logic [1:0] {
        REQ_PUSH,
        REQ_READ,
        REQ_RELEASE,
        REQ_NONE
    } t_req_kind;

    typedef struct packed {
        t_req_kind   kind;
        logic [7:0]  rx_byte;
        logic [8:0]  read_index;
    } t_req;

    typedef struct packed {
        logic        frame_ready;
        logic [8:0]  frame_length;
        logic [7:0]  read_data;
        logic        overflow;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_WAIT,
        ST_PARSE,
        ST_HEAD,
        ST_LEN,
        ST_END,
        ST_OUT
    } t_back_state;

endpackage

@@ src/slefd_ram.sv @@
// ----------------------------------------------------------------------------
// slefd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module slefd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/slefd_front.sv @@
// ----------------------------------------------------------------------------
// slefd_front: request intake and queue
// Accepts input items, decodes the request kind and queues them for the back.
// ----------------------------------------------------------------------------
module slefd_front import slefd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IN_TDATA_W-1:0] i_tdata,
    input  logic [TUSER_W-1:0]    i_tuser,
    output logic                  o_req_valid,
    output t_req                  o_req,
    input  logic                  i_req_pop
);

    t_req              r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    t_req              in_req;
    logic              push;

    // classify the incoming item
    always_comb begin
        in_req.rx_byte    = i_tdata[7:0];
        in_req.read_index = i_tdata[16:8];
        case (i_tuser)
            REQ_CODE_PUSH:    in_req.kind = REQ_PUSH;
            REQ_CODE_READ:    in_req.kind = REQ_READ;
            REQ_CODE_RELEASE: in_req.kind = REQ_RELEASE;
            default:          in_req.kind = REQ_NONE;
        endcase
    end

    assign o_ready     = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push        = i_valid && o_ready;
    assign o_req_valid = (r_count != '0);
    assign o_req       = r_queue[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= in_req;
        end
    end

    // queue pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= QPTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_req_pop) begin
                r_rd_ptr <= QPTR_W'(r_rd_ptr + 1'b1);
            end
            case ({push, i_req_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ src/slefd_back.sv @@
// ----------------------------------------------------------------------------
// slefd_back: request execution and frame parser
// Runs each queued request on the ring, resyncs the head and emits a result.
// ----------------------------------------------------------------------------
module slefd_back import slefd_pkg::*; #(
    parameter int RING_DEPTH = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_start_marker,
    input  logic [7:0] i_end_marker,
    input  logic       i_req_valid,
    input  t_req       i_req,
    output logic       o_req_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_result    o_result
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = PTR_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_EXT = CNT_W'(RING_DEPTH);

    t_back_state      r_state, n_state;
    logic [PTR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             r_held, n_held;
    logic [8:0]       r_held_len, n_held_len;
    logic [8:0]       r_cand_len, n_cand_len;
    logic [7:0]       r_read_data, n_read_data;
    logic             r_ovf, n_ovf;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;

    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [PTR_W-1:0] ram_raddr;
    logic [7:0]       ram_rdata;

    logic             out_free;
    logic             rd_ok;
    logic [8:0]       len_now;

    // ring position of head plus offset, one conditional subtract
    function automatic logic [PTR_W-1:0] f_wrap(input logic [PTR_W-1:0] base,
                                                input logic [PTR_W-1:0] off);
        logic [CNT_W-1:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_EXT) begin
            sum = sum - DEPTH_EXT;
        end
        return sum[PTR_W-1:0];
    endfunction

    slefd_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_req.rx_byte),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || i_out_ready;
    assign rd_ok    = r_held && (i_req.read_index < r_held_len);
    assign len_now  = 9'(HDR_MIN) + {1'b0, ram_rdata};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = (i_req.kind == REQ_READ && rd_ok) ? ST_READ_WAIT : ST_PARSE;
                end
            end
            ST_READ_WAIT: n_state = ST_PARSE;
            ST_PARSE: begin
                n_state = (r_held || r_fill == '0) ? ST_OUT : ST_HEAD;
            end
            ST_HEAD: begin
                if (ram_rdata != i_start_marker) begin
                    n_state = ST_PARSE;
                end else if (r_fill < CNT_W'(HDR_MIN)) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                n_state = (r_fill < CNT_W'(len_now)) ? ST_OUT : ST_END;
            end
            ST_END: begin
                n_state = (ram_rdata != i_end_marker) ? ST_PARSE : ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and ring control
    always_comb begin
        n_head      = r_head;
        n_fill      = r_fill;
        n_held      = r_held;
        n_held_len  = r_held_len;
        n_cand_len  = r_cand_len;
        n_read_data = r_read_data;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_req_pop   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = f_wrap(r_head, r_fill[PTR_W-1:0]);
        ram_raddr   = r_head;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_req_pop   = 1'b1;
                    n_read_data = '0;
                    n_ovf       = 1'b0;
                    case (i_req.kind)
                        REQ_PUSH: begin
                            if (r_fill >= DEPTH_EXT) begin
                                n_ovf = 1'b1;
                            end else begin
                                ram_we = 1'b1;
                                n_fill = r_fill + 1'b1;
                            end
                        end
                        REQ_READ: begin
                            ram_raddr = f_wrap(r_head, PTR_W'(i_req.read_index));
                        end
                        REQ_RELEASE: begin
                            if (r_held) begin
                                n_head     = f_wrap(r_head, PTR_W'(r_held_len));
                                n_fill     = r_fill - CNT_W'(r_held_len);
                                n_held     = 1'b0;
                                n_held_len = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ_WAIT: n_read_data = ram_rdata;
            ST_PARSE: ram_raddr = r_head;
            ST_HEAD: begin
                // wrong start byte: drop one head byte
                if (ram_rdata != i_start_marker) begin
                    n_head = f_wrap(r_head, PTR_W'(1));
                    n_fill = r_fill - 1'b1;
                end else begin
                    ram_raddr = f_wrap(r_head, PTR_W'(LEN_OFFSET));
                end
            end
            ST_LEN: begin
                n_cand_len = len_now;
                ram_raddr  = f_wrap(r_head, PTR_W'(len_now - 9'd1));
            end
            ST_END: begin
                // end byte check: hold frame or drop one head byte
                if (ram_rdata != i_end_marker) begin
                    n_head = f_wrap(r_head, PTR_W'(1));
                    n_fill = r_fill - 1'b1;
                end else begin
                    n_held     = 1'b1;
                    n_held_len = r_cand_len;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.frame_ready  = r_held;
                    n_out.frame_length = r_held_len;
                    n_out.read_data    = r_read_data;
                    n_out.overflow     = r_ovf;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_held      <= 1'b0;
            r_held_len  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_held      <= n_held;
            r_held_len  <= n_held_len;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cand_len  <= n_cand_len;
        r_read_data <= n_read_data;
        r_ovf       <= n_ovf;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

@@ src/start_length_end_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// start_length_end_frame_deframer: start/length/end byte frame deframer
// The back part takes each item off the request queue, waits on the ring read
// for a read request, then parses (PARSE, and HEAD, LEN, END while no frame is
// held) and emits the result in OUT; each byte dropped while resyncing the ring
// head repeats the parse. Items are run one at a time by the serial ring reads of
// the parser; the front queue holds up to four; a stalled result holds the back.
// Reset clears pointers, fill count, held frame, markers and handshakes; no sweep.
// ----------------------------------------------------------------------------
module start_length_end_frame_deframer import slefd_pkg::*; #(
    parameter int RING_DEPTH = 512
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // rx_byte[7:0], read_index[16:8], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type[1:0]
    input  logic [TUSER_W-1:0]     s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // frame_ready[0], frame_length[9:1], read_data[17:10], overflow[18], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [7:0]             i_cfg_wdata
);

    logic [7:0] r_start_marker;
    logic [7:0] r_end_marker;
    logic       req_valid;
    t_req       req;
    logic       req_pop;
    t_result    result;

    // marker registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= '0;
            r_end_marker   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_START_MARKER: r_start_marker <= i_cfg_wdata;
                CFG_END_MARKER:   r_end_marker   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    slefd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .o_req_valid (req_valid),
        .o_req       (req),
        .i_req_pop   (req_pop)
    );

    slefd_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .i_req_valid    (req_valid),
        .i_req          (req),
        .o_req_pop      (req_pop),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_result       (result)
    );

    // result packing, first field in the low bits
    assign m_axis_tdata = {5'b0, result.overflow, result.read_data,
                           result.frame_length, result.frame_ready};

endmodule

@@ tb/sv/start_length_end_frame_deframer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// start_length_end_frame_deframer_tb: self-checking bench for the deframer
// Drives push, read, release and unused requests through the input stream,
// keeps its own copy of the ring and parser state to predict every status
// item, and compares each output item field by field. Phases step through
// several marker settings and idle/stall patterns on both stream sides.
// ----------------------------------------------------------------------------
module start_length_end_frame_deframer_tb;
    import slefd_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RING_DEPTH   = 512;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_ITEMS  = 60;
    localparam int NUM_PHASES   = 8;
    localparam int FLOOD_PUSHES = 530;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // rx_byte[7:0], read_index[16:8], zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // req_type[1:0]
    logic [TUSER_W-1:0]     s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // frame_ready[0], frame_length[9:1], read_data[17:10], overflow[18], zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [7:0]             i_cfg_wdata = '0;

    start_length_end_frame_deframer #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // pending requests and expected status items
    t_req    byte_req_q[$];
    t_result expected_status_q[$];
    t_req    req_on_bus;
    int      queued_count = 0;
    int      error_count = 0;
    int      cycle_count = 0;
    int      src_idle_pct = 0;
    int      sink_stall_pct = 0;

    // shadow deframer state
    logic [7:0] ring_mem [RING_DEPTH];
    int         ring_head = 0;
    int         ring_fill = 0;
    bit         frame_held = 1'b0;
    int         held_len = 0;
    logic [7:0] mk_start = 8'h00;
    logic [7:0] mk_end = 8'h00;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    function automatic logic [7:0] ring_at(input int offset);
        return ring_mem[(ring_head + offset) % RING_DEPTH];
    endfunction

    function automatic void drop_head(input int n);
        ring_head = (ring_head + n) % RING_DEPTH;
        ring_fill -= n;
    endfunction

    // random byte and random read offset over the full field range
    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [8:0] rand_index();
        return 9'($urandom_range(511));
    endfunction

    // apply one request to the shadow state, queue the status it yields
    function automatic void deframe_step(input t_req r);
        t_result status;
        int      flen;
        bit      settled;
        status = '0;
        case (r.kind)
            REQ_PUSH: begin
                if (ring_fill >= RING_DEPTH) begin
                    status.overflow = 1'b1;
                end else begin
                    ring_mem[(ring_head + ring_fill) % RING_DEPTH] = r.rx_byte;
                    ring_fill++;
                end
            end
            REQ_READ: begin
                if (frame_held && int'(r.read_index) < held_len)
                    status.read_data = ring_at(int'(r.read_index));
            end
            REQ_RELEASE: begin
                if (frame_held) begin
                    drop_head(held_len);
                    frame_held = 1'b0;
                    held_len = 0;
                end
            end
            default: ;
        endcase

        // realign the head until a frame is held or more bytes are needed
        settled = 1'b0;
        while (!frame_held && ring_fill > 0 && !settled) begin
            if (ring_at(0) != mk_start) begin
                drop_head(1);
            end else if (ring_fill < HDR_MIN) begin
                settled = 1'b1;
            end else begin
                flen = HDR_MIN + int'(ring_at(LEN_OFFSET));
                if (ring_fill < flen) begin
                    settled = 1'b1;
                end else if (ring_at(flen - 1) != mk_end) begin
                    drop_head(1);
                end else begin
                    frame_held = 1'b1;
                    held_len = flen;
                end
            end
        end

        status.frame_ready  = frame_held;
        status.frame_length = frame_held ? 9'(held_len) : 9'd0;
        expected_status_q.push_back(status);
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                deframe_step(req_on_bus);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (byte_req_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    req_on_bus = byte_req_q.pop_front();
                    s_axis_tdata <= {{(IN_TDATA_W - 17){1'b0}},
                                     req_on_bus.read_index, req_on_bus.rx_byte};
                    s_axis_tuser <= req_on_bus.kind;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output monitor and checker
    always @(posedge i_clk) begin : out_monitor
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_status_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected item 0x%06h", m_axis_tdata));
                end else begin
                    want = expected_status_q.pop_front();
                    if (m_axis_tdata[0] !== want.frame_ready)
                        report_mismatch($sformatf("frame_ready %b, want %b",
                                                  m_axis_tdata[0], want.frame_ready));
                    if (m_axis_tdata[9:1] !== want.frame_length)
                        report_mismatch($sformatf("frame_length %0d, want %0d",
                                                  m_axis_tdata[9:1], want.frame_length));
                    if (m_axis_tdata[17:10] !== want.read_data)
                        report_mismatch($sformatf("read_data 0x%02h, want 0x%02h",
                                                  m_axis_tdata[17:10], want.read_data));
                    if (m_axis_tdata[18] !== want.overflow)
                        report_mismatch($sformatf("overflow %b, want %b",
                                                  m_axis_tdata[18], want.overflow));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("start_length_end_frame_deframer_tb: FAIL");
            $finish;
        end
    end

    task automatic queue_item(input t_req_kind kind, input logic [7:0] value,
                              input logic [8:0] index);
        t_req r;
        r.kind = kind;
        r.rx_byte = value;
        r.read_index = index;
        byte_req_q.push_back(r);
        queued_count++;
    endtask

    // start byte, spare byte, length byte, payload, closing byte
    task automatic queue_frame(input int payload_len, input logic [7:0] close_byte);
        queue_item(REQ_PUSH, mk_start, rand_index());
        queue_item(REQ_PUSH, rand_byte(), rand_index());
        queue_item(REQ_PUSH, 8'(payload_len), rand_index());
        for (int k = 0; k < payload_len; k++)
            queue_item(REQ_PUSH, rand_byte(), rand_index());
        queue_item(REQ_PUSH, close_byte, rand_index());
    endtask

    // mostly in-frame reads, some anywhere in the index range
    task automatic queue_reads(input int frame_len);
        repeat ($urandom_range(4)) begin
            if ($urandom_range(99) < 70)
                queue_item(REQ_READ, rand_byte(), 9'($urandom_range(frame_len - 1)));
            else
                queue_item(REQ_READ, rand_byte(), rand_index());
        end
    endtask

    task automatic gen_traffic(input int n_items, input bit with_flood);
        int         base_count;
        int         pick;
        int         plen;
        logic [7:0] flip;
        // hold a frame, then overrun the ring behind it
        if (with_flood) begin
            queue_frame(0, mk_end);
            repeat (FLOOD_PUSHES)
                queue_item(REQ_PUSH, rand_byte(), rand_index());
            queue_reads(HDR_MIN);
            repeat (3) queue_item(REQ_RELEASE, rand_byte(), rand_index());
        end
        base_count = queued_count;
        while (queued_count - base_count < n_items) begin
            pick = $urandom_range(99);
            plen = $urandom_range(99);
            if (plen < 78)
                plen = $urandom_range(6);
            else if (plen < 96)
                plen = $urandom_range(40, 7);
            else if (plen < 98)
                plen = 255;
            else
                plen = $urandom_range(254, 41);
            if (pick < 55) begin
                // well-formed frame, maybe behind a little junk
                repeat ($urandom_range(2))
                    queue_item(REQ_PUSH, rand_byte(), rand_index());
                queue_frame(plen, mk_end);
                queue_reads(HDR_MIN + plen);
                if ($urandom_range(99) < 85)
                    queue_item(REQ_RELEASE, rand_byte(), rand_index());
            end else if (pick < 70) begin
                // bad closing byte
                flip = 8'($urandom_range(255, 1));
                queue_frame(plen, mk_end ^ flip);
                queue_reads(HDR_MIN + plen);
            end else if (pick < 80) begin
                // truncated header, completed by whatever follows
                queue_item(REQ_PUSH, mk_start, rand_index());
                repeat ($urandom_range(2))
                    queue_item(REQ_PUSH, rand_byte(), rand_index());
            end else begin
                // noise over all request codes
                repeat ($urandom_range(6, 1))
                    queue_item(t_req_kind'($urandom_range(3)), rand_byte(), rand_index());
            end
        end
    endtask

    task automatic write_marker(input logic [CFG_ADDR_W-1:0] addr, input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == CFG_START_MARKER)
            mk_start = value;
        else
            mk_end = value;
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (byte_req_q.size() != 0 || s_axis_tvalid || expected_status_q.size() != 0);
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 66; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 66; end
            default: begin src_idle_pct = 19; sink_stall_pct = 19; end
        endcase
    endtask

    // marker settings per phase, extremes included
    logic [7:0] start_set [NUM_PHASES] = '{8'hA5, 8'hFF, 8'h00, 8'h7E, 8'hFF, 8'h00, 8'h00, 8'h55};
    logic [7:0] end_set   [NUM_PHASES] = '{8'h5A, 8'h00, 8'hFF, 8'h7E, 8'hFF, 8'h00, 8'h00, 8'hAA};

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset markers, no idling
        @(negedge i_clk);
        set_idling(0);
        queue_item(REQ_RELEASE, 8'h00, 9'd0);
        queue_item(REQ_READ, 8'hFF, 9'd0);
        queue_item(REQ_NONE, 8'hFF, 9'h1FF);
        queue_item(REQ_PUSH, 8'hFF, 9'h1FF);
        queue_item(REQ_PUSH, 8'h00, 9'd0);
        queue_item(REQ_PUSH, 8'hFF, 9'd0);
        queue_item(REQ_PUSH, 8'h00, 9'd0);
        queue_item(REQ_PUSH, 8'h00, 9'd0);
        queue_item(REQ_READ, 8'h00, 9'd0);
        queue_item(REQ_READ, 8'h00, 9'd1);
        queue_item(REQ_READ, 8'h00, 9'd3);
        queue_item(REQ_READ, 8'h00, 9'd4);
        queue_item(REQ_READ, 8'h00, 9'h1FF);
        queue_item(REQ_PUSH, 8'hFF, 9'd0);
        queue_item(REQ_NONE, 8'h00, 9'd0);
        queue_item(REQ_RELEASE, 8'h00, 9'd0);
        queue_item(REQ_PUSH, 8'h00, 9'd0);
        queue_item(REQ_PUSH, 8'h55, 9'd0);
        queue_item(REQ_PUSH, 8'h01, 9'd0);
        queue_item(REQ_PUSH, 8'hAA, 9'd0);
        queue_item(REQ_PUSH, 8'h00, 9'd0);
        queue_item(REQ_READ, 8'h00, 9'd2);
        queue_item(REQ_READ, 8'h00, 9'd4);
        wait_drained();

        // random phases, a frame may still be held across a marker change
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph >= 5) begin
                start_set[ph] = rand_byte();
                end_set[ph] = (ph == 5) ? start_set[ph] : rand_byte();
            end
            write_marker(CFG_START_MARKER, start_set[ph]);
            write_marker(CFG_END_MARKER, end_set[ph]);
            @(negedge i_clk);
            set_idling(ph);
            gen_traffic(PHASE_ITEMS, ph == 2);
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("start_length_end_frame_deframer_tb: PASS");
        else
            $display("start_length_end_frame_deframer_tb: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
src/slefd_pkg.sv
src/slefd_ram.sv
src/slefd_front.sv
src/slefd_back.sv
src/start_length_end_frame_deframer.sv
tb/sv/start_length_end_frame_deframer_tb.sv
